>>> rtl/core/asf_pkg.sv
package asf_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CNT_W = (COUNT_WIDTH > 16) ? 16 : COUNT_WIDTH;
	localparam int NUM_DIGITS = 5;
	localparam int MAX_BYTES = NUM_DIGITS + 1;
	localparam int LEN_W = $clog2(MAX_BYTES + 1);

	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] HEX_DIGIT_BASE = 8'd48;
	localparam logic [7:0] HEX_LETTER_BASE = 8'd55;

	typedef enum logic [1:0] {
		MODE_DROP_DIGITS = 2'd0,
		MODE_COUNT_LETTERS = 2'd1,
		MODE_COUNT_SPECIALS = 2'd2,
		MODE_HEX_EXPAND = 2'd3
	} mode_t;

	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0] len;
		logic cnt_inc;
		logic cnt_clr;
	} emit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
			((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? ({4'h0, v} + HEX_DIGIT_BASE) : ({4'h0, v} + HEX_LETTER_BASE);
	endfunction

endpackage

>>> rtl/core/asf_counter.sv
module asf_counter
	import asf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic inc,
	input  logic clr,
	output bcd_t count_bcd
);

	logic [CNT_W-1:0] bin_q;
	bcd_t bcd_q;
	bcd_t bcd_inc;

	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (carry && bcd_q[i] == 4'd9) begin
				bcd_inc[i] = 4'd0;
			end else begin
				bcd_inc[i] = bcd_q[i] + {3'd0, carry};
				carry = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (en) begin
			if (clr) begin
				bin_q <= '0;
				bcd_q <= '0;
			end else if (inc && bin_q != '1) begin
				bin_q <= bin_q + 1'b1;
				bcd_q <= bcd_inc;
			end
		end
	end

	assign count_bcd = bcd_q;

endmodule

>>> rtl/core/asf_emit.sv
module asf_emit
	import asf_pkg::*;
(
	input  mode_t      mode,
	input  logic [7:0] char_in,
	input  logic       is_end,
	input  bcd_t       count_bcd,
	output emit_t      res
);

	logic [LEN_W-1:0] lz;
	logic [LEN_W-1:0] nd;
	bcd_t shifted;

	always_comb begin
		logic found;
		found = 1'b0;
		lz = '0;
		for (int i = NUM_DIGITS - 1; i > 0; i--) begin
			if (!found && count_bcd[i] == 4'd0) begin
				lz = lz + 1'b1;
			end else begin
				found = 1'b1;
			end
		end
	end

	assign nd = LEN_W'(NUM_DIGITS) - lz;
	assign shifted = count_bcd << {lz, 2'b00};

	always_comb begin
		res = '0;
		case (mode)
			MODE_DROP_DIGITS: begin
				if (!is_end && !is_digit(char_in)) begin
					res.bytes[0] = char_in;
					res.len = LEN_W'(1);
				end
			end
			MODE_COUNT_LETTERS, MODE_COUNT_SPECIALS: begin
				if (is_end || char_in == CHAR_NL) begin
					res.cnt_clr = 1'b1;
					for (int j = 0; j < NUM_DIGITS; j++) begin
						res.bytes[j] = {4'h3, shifted[NUM_DIGITS-1-j]};
					end
					if (is_end) begin
						res.len = nd;
					end else begin
						res.bytes[nd] = CHAR_NL;
						res.len = nd + 1'b1;
					end
				end else if (mode == MODE_COUNT_LETTERS) begin
					res.cnt_inc = is_letter(char_in);
				end else begin
					res.cnt_inc = !is_letter(char_in) && !is_digit(char_in) &&
						char_in != CHAR_SPACE;
				end
			end
			MODE_HEX_EXPAND: begin
				if (!is_end) begin
					if (is_digit(char_in) || char_in == CHAR_NL) begin
						res.bytes[0] = char_in;
						res.len = LEN_W'(1);
					end else if (char_in != CHAR_NUL) begin
						if (char_in[7:4] != 4'd0) begin
							res.bytes[0] = hex_char(char_in[7:4]);
							res.bytes[1] = hex_char(char_in[3:0]);
							res.len = LEN_W'(2);
						end else begin
							res.bytes[0] = hex_char(char_in[3:0]);
							res.len = LEN_W'(1);
						end
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/asf_out_buf.sv
module asf_out_buf
	import asf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  emit_t      res,
	input  logic       out_ready,
	output logic       can_load,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic [MAX_BYTES-1:0][7:0] bytes_q;
	logic [LEN_W-1:0] cnt_q;
	logic take;

	assign take = out_valid && out_ready;
	assign can_load = (cnt_q == '0) || (cnt_q == LEN_W'(1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.len;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
		end else if (take) begin
			bytes_q <= bytes_q >> 8;
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_byte = bytes_q[0];
	assign last_of_run = cnt_q == LEN_W'(1);

endmodule

>>> rtl/core/ascii_stream_filter_core.sv
// Output: the results of a request appear in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; a request
// producing n bytes holds the output until all n are taken, and the next request is taken as its last byte leaves.
// Reset: arst_n clears the mode to drop digits, the line count and the
// result buffer asynchronously.
module ascii_stream_filter_core
	import asf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       is_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	mode_t mode_q;
	bcd_t count_bcd;
	emit_t res;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DROP_DIGITS;
		end else if (cfg_wr_en) begin
			mode_q <= mode_t'(cfg_wr_data);
		end
	end

	assign accept = in_valid && in_ready;

	asf_emit u_emit (
		.mode      (mode_q),
		.char_in   (char_in),
		.is_end    (is_end),
		.count_bcd (count_bcd),
		.res       (res)
	);

	asf_counter u_counter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.inc       (res.cnt_inc),
		.clr       (res.cnt_clr),
		.count_bcd (count_bcd)
	);

	asf_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && res.len != '0),
		.res         (res),
		.out_ready   (out_ready),
		.can_load    (in_ready),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

>>> rtl/core/asf_checker.sv
module asf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	// A stalled result byte holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("output changed while stalled");

	// With nothing waiting at the output, a new request is always taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

	// No new request is taken in the middle of a multi-byte burst.
	a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("input ready during a burst");

	// The final byte of a burst leaving frees the input in the same cycle.
	a_ready_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run && out_ready |-> in_ready)
		else $error("input not ready as burst ends");

endmodule

bind ascii_stream_filter_core asf_checker u_asf_checker (.*);

>>> dv/ascii_stream_filter_core_tb.sv
module ascii_stream_filter_core_tb;
	import asf_pkg::*;

	localparam int unsigned CNT_MAX = (COUNT_WIDTH >= 16 || COUNT_WIDTH < 1) ?
		65535 : (1 << COUNT_WIDTH) - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_RUN = 20;
	localparam int RX_HOLD_CYCLES = 150;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic [3:0] gap;
	} req_t;

	typedef struct packed {
		logic [7:0] val;
		logic       last_f;
	} out_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = 2'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_in = 8'd0;
	logic       is_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_of_run;

	req_t pending_chars[$];
	out_t expected_out[$];

	mode_t       filt_mode = MODE_DROP_DIGITS;
	logic [15:0] line_cnt = '0;

	bit tx_fast = 1'b0;
	bit rx_fast = 1'b0;
	int tx_idle = 0;
	int rx_wait = 0;
	int rx_hold = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int errors = 0;
	int n_requests = 0;
	int n_checked = 0;
	int cycles = 0;

	ascii_stream_filter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.is_end      (is_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic filter_model(input logic [7:0] c, input logic fin);
		logic [7:0]  run[$];
		logic [15:0] v;
		logic [3:0]  nib;
		logic        alpha;
		logic        num;
		logic        hit;
		out_t        e;
		alpha = ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
			((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
		num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		case (filt_mode)
			MODE_DROP_DIGITS: begin
				if (!fin && !num)
					run.push_back(c);
			end
			MODE_COUNT_LETTERS, MODE_COUNT_SPECIALS: begin
				if (fin || c == CHAR_NL) begin
					v = line_cnt;
					do begin
						run.push_front(CHAR_ZERO + 8'(v % 16'd10));
						v = v / 16'd10;
					end while (v != 0);
					if (!fin)
						run.push_back(CHAR_NL);
					line_cnt = '0;
				end else begin
					if (filt_mode == MODE_COUNT_LETTERS)
						hit = alpha;
					else
						hit = !alpha && !num && (c != CHAR_SPACE);
					if (hit && line_cnt < CNT_MAX)
						line_cnt = line_cnt + 16'd1;
				end
			end
			default: begin
				if (!fin) begin
					if (num || c == CHAR_NL) begin
						run.push_back(c);
					end else if (c != CHAR_NUL) begin
						nib = c[7:4];
						if (nib != 4'd0)
							run.push_back(nib < 4'd10 ? CHAR_ZERO + nib : HEX_LETTER_BASE + nib);
						nib = c[3:0];
						run.push_back(nib < 4'd10 ? CHAR_ZERO + nib : HEX_LETTER_BASE + nib);
					end
				end
			end
		endcase
		foreach (run[i]) begin
			e.val = run[i];
			e.last_f = (i == run.size() - 1);
			expected_out.push_back(e);
		end
	endtask

	always @(posedge clk) begin : drv
		req_t cur;
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				filter_model(char_in, is_end);
				n_requests++;
				nxt_valid = 1'b0;
				tx_idle = 0;
			end
			if (!nxt_valid && pending_chars.size() != 0) begin
				if (tx_idle >= pending_chars[0].gap) begin
					cur = pending_chars.pop_front();
					char_in <= cur.ch;
					is_end <= cur.fin;
					nxt_valid = 1'b1;
				end else begin
					tx_idle++;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	always @(posedge clk) begin : mon
		out_t e;
		logic nxt_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_checked++;
				if (expected_out.size() == 0) begin
					errors++;
					$display("%0t: unexpected output byte %h last %b", $time, out_byte,
						last_of_run);
				end else begin
					e = expected_out.pop_front();
					if (out_byte !== e.val) begin
						errors++;
						$display("%0t: out_byte expected %h got %h", $time, e.val, out_byte);
					end
					if (last_of_run !== e.last_f) begin
						errors++;
						$display("%0t: last_of_run expected %b got %b", $time, e.last_f,
							last_of_run);
					end
				end
				rx_wait = rx_fast ? 0 : $urandom_range(0, 14);
			end
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				rx_hold = RX_HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				nxt_ready = 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			out_ready <= nxt_ready;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_req(input logic [7:0] c, input logic fin);
		req_t r;
		r.ch = c;
		r.fin = fin;
		r.gap = tx_fast ? 4'd0 : 4'($urandom_range(0, 14));
		pending_chars.push_back(r);
	endtask

	task automatic push_random();
		int k;
		logic [7:0] c;
		k = $urandom_range(0, 19);
		c = 8'($urandom_range(0, 255));
		if (k < 3)
			c = CHAR_UPPER_A + 8'($urandom_range(0, 25));
		else if (k < 6)
			c = CHAR_LOWER_A + 8'($urandom_range(0, 25));
		else if (k < 8)
			c = CHAR_ZERO + 8'($urandom_range(0, 9));
		else if (k == 8)
			c = CHAR_SPACE;
		else if (k < 11)
			c = CHAR_NL;
		else if (k < 15)
			c = 8'h21 + 8'($urandom_range(0, 14));
		push_req(c, k == 11);
	endtask

	task automatic wait_idle();
		while (pending_chars.size() != 0 || in_valid || expected_out.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		filt_mode = m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stim
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_req(8'h2F, 1'b0);
		push_req(CHAR_ZERO, 1'b0);
		push_req(CHAR_NINE, 1'b0);
		push_req(8'h3A, 1'b0);
		push_req(8'hFF, 1'b0);
		push_req(8'h55, 1'b1);
		wait_idle();

		set_mode(MODE_HEX_EXPAND);
		push_req(CHAR_NUL, 1'b0);
		push_req(CHAR_NL, 1'b0);
		push_req(8'h0F, 1'b0);
		push_req(8'h10, 1'b0);
		push_req(8'hFF, 1'b0);
		push_req(8'h35, 1'b0);
		push_req(8'hAA, 1'b1);
		wait_idle();

		set_mode(MODE_COUNT_LETTERS);
		push_req(8'h40, 1'b0);
		push_req(CHAR_UPPER_A, 1'b0);
		push_req(CHAR_UPPER_Z, 1'b0);
		push_req(8'h5B, 1'b0);
		push_req(8'h60, 1'b0);
		push_req(CHAR_LOWER_A, 1'b0);
		push_req(CHAR_LOWER_Z, 1'b0);
		push_req(8'h7B, 1'b0);
		push_req(CHAR_NL, 1'b0);
		wait_idle();

		set_mode(MODE_COUNT_SPECIALS);
		push_req(CHAR_NUL, 1'b0);
		push_req(CHAR_SPACE, 1'b0);
		push_req(CHAR_NINE, 1'b0);
		push_req(8'h80, 1'b0);
		push_req(8'h00, 1'b1);
		wait_idle();

		// A long line of letters gives a two-digit count.
		set_mode(MODE_COUNT_LETTERS);
		tx_fast = 1'b1;
		rx_fast = 1'b1;
		for (int i = 0; i < LONG_RUN; i++)
			push_req(CHAR_LOWER_Z, 1'b0);
		push_req(CHAR_NL, 1'b0);
		wait_idle();

		set_mode(MODE_HEX_EXPAND);
		hold_req++;
		for (int i = 0; i < 30; i++)
			push_random();
		wait_idle();

		for (int p = 0; p < 10; p++) begin
			set_mode(mode_t'($urandom_range(0, 3)));
			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			n = $urandom_range(10, 25);
			for (int i = 0; i < n; i++)
				push_random();
			wait_idle();
		end

		set_mode(MODE_DROP_DIGITS);
		push_req(8'h7E, 1'b0);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Checked %0d output bytes from %0d requests in all four modes,", n_checked,
			n_requests);
		$display("with multi-digit counts, long output back-pressure and sender pauses.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
